@@ rtl/and_gate_constraint_propagator_assert.svh @@
// Assertion macros shared by the propagator RTL.
// Each expects i_clk and i_rst_n to be visible where it is used.
`ifndef AND_GATE_CONSTRAINT_PROPAGATOR_ASSERT_SVH
`define AND_GATE_CONSTRAINT_PROPAGATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AGCP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AGCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/agcp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and codes of the AND-gate constraint propagator.
// No dependencies.
package agcp_pkg;

    localparam int MAX_VARS      = 4096;
    localparam int MAX_EQUATIONS = 4096;
    localparam int VAR_AW        = $clog2(MAX_VARS);
    localparam int EQ_AW         = $clog2(MAX_EQUATIONS);
    localparam int LIT_W         = 13;
    localparam int GATE_W        = 3 * LIT_W;
    localparam int CFG_EQ_W      = 13;
    localparam int CFG_VAR_W     = 12;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    typedef enum logic [2:0] {
        OP_LOAD  = 3'd0,
        OP_WRITE = 3'd1,
        OP_CLEAR = 3'd2,
        OP_SOLVE = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]       op;
        logic [11:0]      eq_index;
        logic [LIT_W-1:0] out_lit;
        logic [LIT_W-1:0] in_lit_a;
        logic [LIT_W-1:0] in_lit_b;
        logic [11:0]      var_index;
        logic             var_bit;
        logic             var_known;
    } t_in_word;

    typedef struct packed {
        logic status;
        logic all_fixed;
        logic read_bit;
        logic read_known;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_CLR, ST_RDV, ST_GATE, ST_VX, ST_VY,
        ST_VZ, ST_WZ, ST_EVAL, ST_WR2, ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        VS_IN, VS_X, VS_Y, VS_Z
    } t_vsel;

    typedef struct packed {
        logic  acc;
        logic  push;
        logic  gate_wr;
        logic  gate_rd;
        logic  var_wr_in;
        logic  var_rd;
        t_vsel vsel;
        logic  lat_x;
        logic  lat_y;
        logic  lat_z;
        logic  lat_read;
        logic  sweep_wr;
        logic  j_one;
        logic  j_inc;
        logic  k_clr;
        logic  k_inc;
        logic  chg_clr;
        logic  chg_set;
        logic  ded_wr1;
        logic  ded_wr2;
        logic  set_status;
        logic  set_fixed;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic j_last;
        logic j_over;
        logic k_done;
        logic changed;
        logic conflict;
        logic deduced;
        logic wr1_en;
        logic wr2_en;
        logic chk_fail;
    } t_sts;

endpackage

@@ rtl/agcp_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input and result words.
// Depends on agcp_pkg.
interface agcp_in_if;
    import agcp_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface agcp_out_if;
    import agcp_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/and_gate_constraint_propagator.sv @@
`timescale 1ns / 1ps
// AND-gate constraint propagator: top level.
// Depends on agcp_pkg, agcp_if, agcp_ram, agcp_ctrl and agcp_dp.
//
// Usage: input words arrive on i_in (valid/ready), one result word per input
// word leaves on o_out (valid/ready). Two registers sit on the APB-style port:
// active_equations at byte address 0 and active_vars at byte address 4; write
// them only while the block is idle.
// Load, write and unknown-op words have their result valid in the next cycle.
// A read latches the variable's value and known bit before the result is
// handed off. A clear walks the known-bit store one variable a cycle. A solve
// walks the gate table through the single read port of each variable store:
// every gate takes a gate-table read, three variable reads, a wait for the
// last read and an evaluation, plus a second write when two inputs are
// deduced at once. When a pass changes nothing, a final settle check pass
// walks the gates again.
// After reset the block clears all 4096 known bits before it raises ready.
// The result register holds a word until the receiver takes it; while it is
// full and not being drained no new input word is accepted.
module and_gate_constraint_propagator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    agcp_in_if.sink                       i_in,
    agcp_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [agcp_pkg::PADDR_W-1:0]  paddr,
    input  logic [agcp_pkg::PDATA_W-1:0]  pwdata,
    output logic [agcp_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import agcp_pkg::*;

    logic [CFG_EQ_W-1:0]  r_active_eq;
    logic [CFG_VAR_W-1:0] r_active_vars;
    logic                 w_cfg_wr;
    t_cmd                 w_cmd;
    t_sts                 w_sts;

    // Registers are decoded on address bit 2 only; the low address bits are ignored.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_eq   <= '0;
            r_active_vars <= '0;
        end else if (w_cfg_wr) begin
            if (!paddr[2]) begin
                // Saturate the equation count at the table depth.
                if (pwdata[CFG_EQ_W-1:0] > CFG_EQ_W'(MAX_EQUATIONS)) begin
                    r_active_eq <= CFG_EQ_W'(MAX_EQUATIONS);
                end else begin
                    r_active_eq <= pwdata[CFG_EQ_W-1:0];
                end
            end else begin
                r_active_vars <= pwdata[CFG_VAR_W-1:0];
            end
        end
    end

    assign prdata = paddr[2] ? PDATA_W'(r_active_vars) : PDATA_W'(r_active_eq);

    agcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_op       (i_in.data.op),
        .i_sts      (w_sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd)
    );

    agcp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_word        (i_in.data),
        .i_active_eq   (r_active_eq),
        .i_active_vars (r_active_vars),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_out_word    (o_out.data),
        .o_sts         (w_sts)
    );

`include "and_gate_constraint_propagator_assert.svh"

    // Input is taken only when the result register can take the new word.
    `AGCP_ASSERT_SAME(a_ready_slot, i_in.ready, !(o_out.valid && !o_out.ready), "ready with result stuck")
    // The equation count never exceeds the table depth.
    `AGCP_ASSERT_SAME(a_eq_sat, 1'b1, r_active_eq <= CFG_EQ_W'(MAX_EQUATIONS), "equation count too large")
    // Loads and writes answer in the next cycle.
    `AGCP_ASSERT_NEXT(a_fast_ops, i_in.valid && i_in.ready && (i_in.data.op == OP_LOAD || i_in.data.op == OP_WRITE), o_out.valid, "fast op result missing")
    // A contradiction never reports a settled table.
    `AGCP_ASSERT_SAME(a_conflict_fixed, o_out.valid && o_out.data.status, !o_out.data.all_fixed, "conflict with all_fixed")

endmodule

@@ rtl/agcp_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module agcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/agcp_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the propagator: clearing sweeps, gate passes and result hand-off.
// Depends on agcp_pkg.
module agcp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [2:0]      i_op,
    input  agcp_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output agcp_pkg::t_cmd  o_cmd
);
    import agcp_pkg::*;

    t_state r_state, n_state;
    logic   r_chk, n_chk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chk   <= n_chk;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_chk      = r_chk;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_INIT: begin
                o_cmd.sweep_wr = 1'b1;
                o_cmd.j_inc    = 1'b1;
                if (i_sts.j_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = i_sts.slot_free;
                if (i_in_valid && i_sts.slot_free) begin
                    o_cmd.acc = 1'b1;
                    case (i_op)
                        OP_LOAD: begin
                            o_cmd.gate_wr = 1'b1;
                            o_cmd.push    = 1'b1;
                        end
                        OP_WRITE: begin
                            o_cmd.var_wr_in = 1'b1;
                            o_cmd.push      = 1'b1;
                        end
                        OP_CLEAR: begin
                            o_cmd.j_one = 1'b1;
                            n_state     = ST_CLR;
                        end
                        OP_SOLVE: begin
                            o_cmd.k_clr   = 1'b1;
                            o_cmd.chg_clr = 1'b1;
                            n_chk         = 1'b0;
                            n_state       = ST_GATE;
                        end
                        OP_READ: begin
                            o_cmd.var_rd = 1'b1;
                            o_cmd.vsel   = VS_IN;
                            n_state      = ST_RDV;
                        end
                        default: begin
                            o_cmd.push = 1'b1;
                        end
                    endcase
                end
            end
            ST_CLR: begin
                if (i_sts.j_over) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.sweep_wr = 1'b1;
                    o_cmd.j_inc    = 1'b1;
                end
            end
            ST_RDV: begin
                o_cmd.lat_read = 1'b1;
                n_state        = ST_FIN;
            end
            ST_GATE: begin
                if (i_sts.k_done) begin
                    o_cmd.k_clr = 1'b1;
                    if (r_chk) begin
                        o_cmd.set_fixed = 1'b1;
                        n_state         = ST_FIN;
                    end else if (i_sts.changed) begin
                        o_cmd.chg_clr = 1'b1;
                    end else begin
                        n_chk = 1'b1;
                    end
                end else begin
                    o_cmd.gate_rd = 1'b1;
                    n_state       = ST_VX;
                end
            end
            ST_VX: begin
                o_cmd.var_rd = 1'b1;
                o_cmd.vsel   = VS_X;
                n_state      = ST_VY;
            end
            ST_VY: begin
                o_cmd.lat_x  = 1'b1;
                o_cmd.var_rd = 1'b1;
                o_cmd.vsel   = VS_Y;
                n_state      = ST_VZ;
            end
            ST_VZ: begin
                o_cmd.lat_y  = 1'b1;
                o_cmd.var_rd = 1'b1;
                o_cmd.vsel   = VS_Z;
                n_state      = ST_WZ;
            end
            ST_WZ: begin
                o_cmd.lat_z = 1'b1;
                n_state     = ST_EVAL;
            end
            ST_EVAL: begin
                if (r_chk) begin
                    if (i_sts.chk_fail) begin
                        n_state = ST_FIN;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state     = ST_GATE;
                    end
                end else if (i_sts.conflict) begin
                    o_cmd.set_status = 1'b1;
                    n_state          = ST_FIN;
                end else begin
                    o_cmd.ded_wr1 = i_sts.wr1_en;
                    o_cmd.chg_set = i_sts.deduced;
                    if (i_sts.wr2_en) begin
                        n_state = ST_WR2;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state     = ST_GATE;
                    end
                end
            end
            ST_WR2: begin
                o_cmd.ded_wr2 = 1'b1;
                o_cmd.k_inc   = 1'b1;
                n_state       = ST_GATE;
            end
            ST_FIN: begin
                if (i_sts.slot_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

@@ rtl/agcp_dp.sv @@
`timescale 1ns / 1ps
// Datapath: gate table, variable stores, counters, gate evaluation, result register.
// Depends on agcp_pkg and agcp_ram.
module agcp_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  agcp_pkg::t_cmd               i_cmd,
    input  agcp_pkg::t_in_word           i_word,
    input  logic [agcp_pkg::CFG_EQ_W-1:0]  i_active_eq,
    input  logic [agcp_pkg::CFG_VAR_W-1:0] i_active_vars,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output agcp_pkg::t_out_word          o_out_word,
    output agcp_pkg::t_sts               o_sts
);
    import agcp_pkg::*;

    // Counters and flags.
    logic [EQ_AW:0]    r_k;
    logic [VAR_AW:0]   r_j;
    logic              r_changed;
    logic              r_status, r_fixed, r_rbit, r_rknown;
    logic              r_out_valid;
    t_out_word         r_out_word;

    // Operands of the gate under evaluation.
    logic              r_kx, r_vx, r_ky, r_vy, r_kz, r_vz;

    logic [GATE_W-1:0] w_gate;
    logic [LIT_W-1:0]  w_lx, w_ly, w_lz;
    logic [VAR_AW-1:0] w_x, w_y, w_z;
    logic              w_val_rd, w_known_rd;

    logic              w_ix, w_iy, w_iz, w_vx, w_vy, w_vz;
    logic              w_low_in;
    logic              w_conflict, w_wr1_en, w_wr2_en;
    logic [VAR_AW-1:0] w_wr1_var;
    logic              w_wr1_val;

    logic [VAR_AW-1:0] w_rd_addr;
    logic              w_val_we, w_known_we;
    logic [VAR_AW-1:0] w_val_wa, w_known_wa;
    logic              w_val_wd, w_known_wd;

    assign w_lx = w_gate[3*LIT_W-1:2*LIT_W];
    assign w_ly = w_gate[2*LIT_W-1:LIT_W];
    assign w_lz = w_gate[LIT_W-1:0];
    assign w_x  = w_lx[VAR_AW:1];
    assign w_y  = w_ly[VAR_AW:1];
    assign w_z  = w_lz[VAR_AW:1];
    assign w_ix = w_lx[0];
    assign w_iy = w_ly[0];
    assign w_iz = w_lz[0];
    assign w_vx = r_vx ^ w_ix;
    assign w_vy = r_vy ^ w_iy;
    assign w_vz = r_vz ^ w_iz;

    // An input known false forces the output false.
    assign w_low_in = (r_ky && !w_vy) || (r_kz && !w_vz);

    always_comb begin
        w_conflict = 1'b0;
        w_wr1_en   = 1'b0;
        w_wr2_en   = 1'b0;
        w_wr1_var  = w_x;
        w_wr1_val  = w_ix;
        if (r_kx && r_ky && r_kz) begin
            w_conflict = (w_vx != (w_vy & w_vz));
        end else if (!r_kx) begin
            w_wr1_var = w_x;
            if (w_low_in) begin
                w_wr1_en  = 1'b1;
                w_wr1_val = w_ix;
            end else if (r_ky && w_vy && r_kz && w_vz) begin
                w_wr1_en  = 1'b1;
                w_wr1_val = ~w_ix;
            end
        end else if (!w_vx) begin
            if (r_ky && w_vy) begin
                w_wr1_en  = 1'b1;
                w_wr1_var = w_z;
                w_wr1_val = w_iz;
            end else if (r_kz && w_vz) begin
                w_wr1_en  = 1'b1;
                w_wr1_var = w_y;
                w_wr1_val = w_iy;
            end
        end else if (w_low_in) begin
            w_conflict = 1'b1;
        end else begin
            // Output true: every unknown input becomes true.
            w_wr1_en  = 1'b1;
            w_wr1_var = r_ky ? w_z : w_y;
            w_wr1_val = r_ky ? ~w_iz : ~w_iy;
            w_wr2_en  = !r_ky && !r_kz && (w_z != w_y);
        end
    end

    always_comb begin
        case (i_cmd.vsel)
            VS_IN:   w_rd_addr = i_word.var_index[VAR_AW-1:0];
            VS_X:    w_rd_addr = w_x;
            VS_Y:    w_rd_addr = w_y;
            VS_Z:    w_rd_addr = w_z;
            default: w_rd_addr = w_x;
        endcase
    end

    always_comb begin
        w_val_we   = i_cmd.var_wr_in || i_cmd.ded_wr1 || i_cmd.ded_wr2;
        w_known_we = w_val_we || i_cmd.sweep_wr;
        if (i_cmd.var_wr_in) begin
            w_val_wa   = i_word.var_index[VAR_AW-1:0];
            w_val_wd   = i_word.var_bit;
            w_known_wa = i_word.var_index[VAR_AW-1:0];
            w_known_wd = i_word.var_known;
        end else if (i_cmd.ded_wr1) begin
            w_val_wa   = w_wr1_var;
            w_val_wd   = w_wr1_val;
            w_known_wa = w_wr1_var;
            w_known_wd = 1'b1;
        end else if (i_cmd.ded_wr2) begin
            w_val_wa   = w_z;
            w_val_wd   = ~w_iz;
            w_known_wa = w_z;
            w_known_wd = 1'b1;
        end else begin
            w_val_wa   = w_z;
            w_val_wd   = 1'b0;
            w_known_wa = r_j[VAR_AW-1:0];
            w_known_wd = 1'b0;
        end
    end

    agcp_ram #(.WIDTH(GATE_W), .DEPTH(MAX_EQUATIONS)) u_gate_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.gate_wr),
        .i_waddr (i_word.eq_index[EQ_AW-1:0]),
        .i_wdata ({i_word.out_lit, i_word.in_lit_a, i_word.in_lit_b}),
        .i_re    (i_cmd.gate_rd),
        .i_raddr (r_k[EQ_AW-1:0]),
        .o_rdata (w_gate)
    );

    agcp_ram #(.WIDTH(1), .DEPTH(MAX_VARS)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_waddr (w_val_wa),
        .i_wdata (w_val_wd),
        .i_re    (i_cmd.var_rd),
        .i_raddr (w_rd_addr),
        .o_rdata (w_val_rd)
    );

    agcp_ram #(.WIDTH(1), .DEPTH(MAX_VARS)) u_known_ram (
        .i_clk   (i_clk),
        .i_we    (w_known_we),
        .i_waddr (w_known_wa),
        .i_wdata (w_known_wd),
        .i_re    (i_cmd.var_rd),
        .i_raddr (w_rd_addr),
        .o_rdata (w_known_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_j         <= '0;
            r_changed   <= 1'b0;
            r_status    <= 1'b0;
            r_fixed     <= 1'b0;
            r_rbit      <= 1'b0;
            r_rknown    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.k_clr) begin
                r_k <= '0;
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.j_one) begin
                r_j <= (VAR_AW+1)'(1);
            end else if (i_cmd.j_inc) begin
                r_j <= r_j + 1'b1;
            end
            if (i_cmd.chg_clr) begin
                r_changed <= 1'b0;
            end else if (i_cmd.chg_set) begin
                r_changed <= 1'b1;
            end
            if (i_cmd.acc) begin
                r_status <= 1'b0;
                r_fixed  <= 1'b0;
                r_rbit   <= 1'b0;
                r_rknown <= 1'b0;
            end else begin
                if (i_cmd.set_status) begin
                    r_status <= 1'b1;
                end
                if (i_cmd.set_fixed) begin
                    r_fixed <= 1'b1;
                end
                if (i_cmd.lat_read) begin
                    r_rbit   <= w_val_rd;
                    r_rknown <= w_known_rd;
                end
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_x) begin
            r_kx <= w_known_rd;
            r_vx <= w_val_rd;
        end
        if (i_cmd.lat_y) begin
            r_ky <= w_known_rd;
            r_vy <= w_val_rd;
        end
        if (i_cmd.lat_z) begin
            r_kz <= w_known_rd;
            r_vz <= w_val_rd;
        end
        if (i_cmd.push) begin
            r_out_word <= i_cmd.acc ? '0 : {r_status, r_fixed, r_rbit, r_rknown};
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_word       = r_out_word;
    assign o_sts.slot_free  = !r_out_valid || i_out_ready;
    assign o_sts.j_last     = (r_j[VAR_AW-1:0] == VAR_AW'(MAX_VARS - 1));
    assign o_sts.j_over     = (r_j > (VAR_AW+1)'(i_active_vars));
    assign o_sts.k_done     = ((CFG_EQ_W)'(r_k) == i_active_eq);
    assign o_sts.changed    = r_changed;
    assign o_sts.conflict   = w_conflict;
    assign o_sts.deduced    = w_wr1_en;
    assign o_sts.wr1_en     = w_wr1_en;
    assign o_sts.wr2_en     = w_wr2_en;
    assign o_sts.chk_fail   = !r_ky && !r_kz && !(r_kx && w_vx);
endmodule
